FILE: rtl/core/amia_pkg.sv
`timescale 1ns / 1ps

package amia_pkg;

   localparam int DataBitsDefault = 32;
   localparam int OperandBits = 32;
   localparam int ResultBits = 32;

   localparam logic [2:0] KIND_NOT = 3'd0;
   localparam logic [2:0] KIND_FIND_LEFT = 3'd1;
   localparam logic [2:0] KIND_FIND_RIGHT = 3'd2;
   localparam logic [2:0] KIND_FROM_BCD = 3'd3;
   localparam logic [2:0] KIND_TO_BCD = 3'd4;
   localparam logic [2:0] KIND_STORE = 3'd5;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic [13:0] BcdLimit = 14'd9999;

   typedef struct packed {
      logic [2:0] kind;
      logic [OperandBits-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [ResultBits-1:0] result;
      logic status;
   } rsp_type;

endpackage

FILE: rtl/core/aml_monadic_integer_alu.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   amia_pkg::req_type (kind, operand)
// rsp      out        rsp_valid / rsp_stall   amia_pkg::rsp_type (result, status)
// One transaction is accepted per cycle while req_stall is low; its response passes through the input
// register, the operator logic and the result register before it is presented.
// Reset is synchronous and clears only the two valid flags.
// A stalled response holds the result register; the input register keeps
// accepting while it is empty, so req_stall rises only when both stages are full.

module aml_monadic_integer_alu #(
   parameter int DATA_BITS = amia_pkg::DataBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  amia_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output amia_pkg::rsp_type rsp_data
);

   logic in_valid_ff;
   logic in_valid_in;
   amia_pkg::req_type in_data_ff;
   logic out_valid_ff;
   logic out_valid_in;
   amia_pkg::rsp_type out_data_ff;
   amia_pkg::rsp_type computed;
   logic out_free;
   logic in_load;
   logic move;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign move = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load = req_valid && !req_stall;

   assign in_valid_in = in_load || (in_valid_ff && !out_free);
   assign out_valid_in = move || (out_valid_ff && rsp_stall);

   amia_compute #(
      .DATA_BITS(DATA_BITS)
   ) u_compute (
      .req(in_data_ff),
      .rsp(computed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         out_data_ff <= computed;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

`ifndef SYNTHESIS
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status |-> out_data_ff.result == '0)
      else $error("Error response carries a nonzero result.");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("Request stalled while a stage is empty.");

   a_move_fills_output: assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("Transaction moved to output but output is empty.");

   a_held_input_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_data_ff))
      else $error("Blocked transaction in input register was lost.");
`endif

endmodule

FILE: rtl/core/amia_compute.sv
`timescale 1ns / 1ps

module amia_compute #(
   parameter int DATA_BITS = amia_pkg::DataBitsDefault
) (
   input  amia_pkg::req_type req,
   output amia_pkg::rsp_type rsp
);

   localparam int WordBits = (DATA_BITS < amia_pkg::OperandBits) ? DATA_BITS
                                                                  : amia_pkg::OperandBits;

   logic [amia_pkg::OperandBits-1:0] word_mask;
   logic [amia_pkg::OperandBits-1:0] x;
   logic [5:0] left_index;
   logic [5:0] right_index;
   logic [3:0] bcd_digit [4];
   logic bcd_bad;
   logic [13:0] bcd_value;
   logic [13:0] x14;
   logic [29:0] prod10;
   logic [26:0] prod100;
   logic [26:0] prod1000;
   logic [9:0] q10;
   logic [7:0] q100;
   logic [3:0] q1000;
   logic [13:0] rem0;
   logic [9:0] rem1;
   logic [7:0] rem2;
   logic to_bcd_over;
   logic [amia_pkg::ResultBits-1:0] value;
   logic error;

   always_comb begin
      for (int i = 0; i < amia_pkg::OperandBits; i++) begin
         word_mask[i] = (i < WordBits);
      end
   end

   assign x = req.operand & word_mask;

   always_comb begin
      left_index = 6'd0;
      for (int i = 0; i < amia_pkg::OperandBits; i++) begin
         if (x[i]) begin
            left_index = 6'(i + 1);
         end
      end
   end

   always_comb begin
      right_index = 6'd0;
      for (int i = amia_pkg::OperandBits - 1; i >= 0; i--) begin
         if (x[i]) begin
            right_index = 6'(i + 1);
         end
      end
   end

   always_comb begin
      bcd_bad = 1'b0;
      for (int i = 0; i < 4; i++) begin
         bcd_digit[i] = x[4*i +: 4];
         if (bcd_digit[i] > 4'd9) begin
            bcd_bad = 1'b1;
         end
      end
   end

   assign bcd_value = 14'(bcd_digit[0]) + 14'(bcd_digit[1]) * 14'd10
                    + 14'(bcd_digit[2]) * 14'd100 + 14'(bcd_digit[3]) * 14'd1000;

   // Quotients by 10, 100 and 1000 use reciprocal multiplication; they are exact below 10000.
   assign to_bcd_over = (x > 32'(amia_pkg::BcdLimit));
   assign x14 = x[13:0];
   assign prod10 = 30'(x14) * 30'd6554;
   assign prod100 = 27'(x14) * 27'd5243;
   assign prod1000 = 27'(x14) * 27'd8389;
   assign q10 = prod10[25:16];
   assign q100 = prod100[26:19];
   assign q1000 = prod1000[26:23];
   assign rem0 = x14 - 14'(q10) * 14'd10;
   assign rem1 = q10 - 10'(q100) * 10'd10;
   assign rem2 = q100 - 8'(q1000) * 8'd10;

   always_comb begin
      value = '0;
      error = amia_pkg::STATUS_OK;
      unique case (req.kind)
         amia_pkg::KIND_NOT: begin
            value = ~x & word_mask;
         end
         amia_pkg::KIND_FIND_LEFT: begin
            value = 32'(left_index);
         end
         amia_pkg::KIND_FIND_RIGHT: begin
            value = 32'(right_index);
         end
         amia_pkg::KIND_FROM_BCD: begin
            error = bcd_bad;
            value = 32'(bcd_value);
         end
         amia_pkg::KIND_TO_BCD: begin
            error = to_bcd_over;
            value = {16'd0, q1000, rem2[3:0], rem1[3:0], rem0[3:0]};
         end
         amia_pkg::KIND_STORE: begin
            value = x;
         end
         default: begin
            error = amia_pkg::STATUS_ERROR;
         end
      endcase
   end

   assign rsp.result = error ? '0 : value;
   assign rsp.status = error;

endmodule
